@@ hw/rtl/tnc_pkg.sv @@
package tnc_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned CountWidthDef = 16;

  // Error codes as they appear on the result word.
  typedef logic [1:0] err_t;
  localparam err_t ErrNone     = 2'd0;
  localparam err_t ErrMismatch = 2'd1;
  localparam err_t ErrUnclosed = 2'd2;
  localparam err_t ErrOverflow = 2'd3;

  // Tag kind codes as they are kept on the stack.
  typedef logic [1:0] kind_code_t;
  localparam kind_code_t KindPara   = 2'd0;
  localparam kind_code_t KindBold   = 2'd1;
  localparam kind_code_t KindItalic = 2'd2;
  localparam kind_code_t KindQuote  = 2'd3;

  // Characters that make up the tags.
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChQ     = 8'h71;

  typedef struct packed {
    logic       hit;
    kind_code_t kind;
  } kind_t;

  // Maps a tag letter to its kind code; hit is low for any other byte.
  function automatic kind_t kind_of(input logic [7:0] c);
    kind_t k;
    k.hit  = 1'b1;
    k.kind = KindPara;
    unique case (c)
      ChP:     k.kind = KindPara;
      ChB:     k.kind = KindBold;
      ChI:     k.kind = KindItalic;
      ChQ:     k.kind = KindQuote;
      default: k.hit  = 1'b0;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/tnc_ifs.sv @@
interface tnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface tnc_out_if #(
  parameter int unsigned CountWidth = tnc_pkg::CountWidthDef
);
  logic                  valid;
  logic                  ready;
  logic                  balanced;
  logic [1:0]            error_code;
  logic [CountWidth-1:0] para_pairs;
  logic [CountWidth-1:0] bold_pairs;
  logic [CountWidth-1:0] italic_pairs;
  logic [CountWidth-1:0] quote_pairs;

  modport source (output valid, output balanced, output error_code, output para_pairs,
                  output bold_pairs, output italic_pairs, output quote_pairs, input ready);
  modport sink   (input valid, input balanced, input error_code, input para_pairs,
                  input bold_pairs, input italic_pairs, input quote_pairs, output ready);
endinterface

@@ hw/rtl/tag_nesting_checker_core.sv @@
// Tag nesting checker for one line body, streamed one byte per word.
// Input channel in_i carries char_in and last_char; the word with last_char
// set closes the line. Output channel out_o carries one result word per line:
// balanced, error_code and the four saturating pair counts.
// Throughput is one input word per cycle. Every byte is examined in the cycle
// it is accepted, against the three bytes held in a sliding window register,
// and the stack takes at most one push or pop per cycle. The result word is
// valid in the cycle after the last byte is accepted.
// The block takes a new word whenever the result register is empty or its
// word is being taken in the same cycle, so a stalled receiver holds the
// result and stalls the input only while that result is waiting.
// Reset (asynchronous, active low) empties the window, the stack and the
// counters and clears any pending result; no clearing pass is needed since
// stack entries are only read below the current depth. After each result the
// block returns to the same empty state for the next line.
module tag_nesting_checker_core #(
  parameter int unsigned StackDepth = tnc_pkg::StackDepthDef,
  parameter int unsigned CountWidth = tnc_pkg::CountWidthDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  tnc_in_if.sink   in_i,
  tnc_out_if.source out_o
);

  localparam int unsigned AddrW  = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned DepthW = $clog2(StackDepth + 1);
  localparam logic [DepthW-1:0] DepthFull = DepthW'(StackDepth);

  // Line state.
  logic [23:0]                   win_q, win_d;
  logic [1:0]                    fill_q, fill_d;
  logic [1:0]                    skip_q, skip_d;
  logic [DepthW-1:0]             depth_q, depth_d;
  tnc_pkg::err_t                 err_q, err_d;
  tnc_pkg::kind_code_t           top_q, top_d;
  tnc_pkg::kind_code_t           below_q;
  logic [3:0][CountWidth-1:0]    cnt_q, cnt_d;

  // The stack entries below the top; the top itself lives in top_q.
  tnc_pkg::kind_code_t stack_mem [StackDepth];

  // Result register.
  logic                          out_valid_q;
  logic                          bal_q;
  tnc_pkg::err_t                 res_err_q;
  logic [3:0][CountWidth-1:0]    res_cnt_q;

  logic accept;
  logic last;
  logic [7:0] c;
  logic [7:0] b0, b1, b2;
  tnc_pkg::kind_t open_k, close_k, flush_k;
  logic open_hit, close_hit, flush_open;
  logic push, pop;
  logic [23:0] win_e;
  logic [1:0]  fill_e;
  logic [1:0]  skip_e;
  logic [DepthW-1:0] depth_e;
  tnc_pkg::err_t err_e, final_err;
  tnc_pkg::kind_code_t top_e;
  logic [3:0][CountWidth-1:0] cnt_e;
  logic [DepthW-1:0] rd_depth;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign last       = in_i.last_char;
  assign c          = in_i.char_in;

  assign b0 = win_q[7:0];
  assign b1 = win_q[15:8];
  assign b2 = win_q[23:16];

  // The window position starting at b0 sees b0, b1, b2 and the new byte.
  assign open_k    = tnc_pkg::kind_of(b1);
  assign close_k   = tnc_pkg::kind_of(b2);
  assign open_hit  = (b0 == tnc_pkg::ChLt) && (b2 == tnc_pkg::ChGt) && open_k.hit;
  assign close_hit = (b0 == tnc_pkg::ChLt) && (b1 == tnc_pkg::ChSlash) &&
                     (c == tnc_pkg::ChGt) && close_k.hit;

  // Examine the oldest window position, once the window holds three bytes.
  always_comb begin
    skip_e  = skip_q;
    err_e   = err_q;
    depth_e = depth_q;
    top_e   = top_q;
    cnt_e   = cnt_q;
    push    = 1'b0;
    pop     = 1'b0;
    if (fill_q == 2'd3 && err_q == tnc_pkg::ErrNone) begin
      priority if (skip_q != 2'd0) begin
        skip_e = skip_q - 2'd1;
      end else if (open_hit) begin
        if (depth_q == DepthFull) begin
          err_e = tnc_pkg::ErrOverflow;
        end else begin
          push = 1'b1;
        end
        skip_e = 2'd2;
      end else if (close_hit) begin
        if (depth_q != '0 && top_q == close_k.kind) begin
          pop = 1'b1;
        end else begin
          err_e = tnc_pkg::ErrMismatch;
        end
        skip_e = 2'd3;
      end else begin
        skip_e = skip_q;
      end
    end
    if (push) begin
      depth_e = depth_q + DepthW'(1);
      top_e   = open_k.kind;
    end
    if (pop) begin
      depth_e = depth_q - DepthW'(1);
      top_e   = below_q;
    end
    // Each counter saturates at its all-ones value.
    for (int i = 0; i < 4; i++) begin
      if (pop && close_k.kind == 2'(i) && cnt_q[i] != '1) begin
        cnt_e[i] = cnt_q[i] + CountWidth'(1);
      end
    end
  end

  // Shift the new byte into the window.
  always_comb begin
    win_e  = win_q;
    fill_e = fill_q;
    unique case (fill_q)
      2'd0: begin
        win_e[7:0] = c;
        fill_e     = 2'd1;
      end
      2'd1: begin
        win_e[15:8] = c;
        fill_e      = 2'd2;
      end
      2'd2: begin
        win_e[23:16] = c;
        fill_e       = 2'd3;
      end
      default: begin
        win_e  = {c, win_q[23:8]};
        fill_e = 2'd3;
      end
    endcase
  end

  // At the end of the line only the first padded position can still hold a
  // tag, and only an opening one, since a closing tag would need its final
  // byte from the zero padding. A push there always leaves the stack non-empty.
  assign flush_k    = tnc_pkg::kind_of(win_e[15:8]);
  assign flush_open = (fill_e == 2'd3) && (err_e == tnc_pkg::ErrNone) &&
                      (skip_e == 2'd0) && (win_e[7:0] == tnc_pkg::ChLt) &&
                      (win_e[23:16] == tnc_pkg::ChGt) && flush_k.hit;

  always_comb begin
    priority if (err_e != tnc_pkg::ErrNone) begin
      final_err = err_e;
    end else if (flush_open) begin
      final_err = (depth_e == DepthFull) ? tnc_pkg::ErrOverflow : tnc_pkg::ErrUnclosed;
    end else if (depth_e != '0) begin
      final_err = tnc_pkg::ErrUnclosed;
    end else begin
      final_err = tnc_pkg::ErrNone;
    end
  end

  // Next state: a last byte returns the line state to empty.
  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    skip_d  = skip_q;
    depth_d = depth_q;
    err_d   = err_q;
    top_d   = top_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (last) begin
        win_d   = '0;
        fill_d  = '0;
        skip_d  = '0;
        depth_d = '0;
        err_d   = tnc_pkg::ErrNone;
        cnt_d   = '0;
      end else begin
        win_d   = win_e;
        fill_d  = fill_e;
        skip_d  = skip_e;
        depth_d = depth_e;
        err_d   = err_e;
        top_d   = top_e;
        cnt_d   = cnt_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      skip_q  <= '0;
      depth_q <= '0;
      err_q   <= tnc_pkg::ErrNone;
      top_q   <= tnc_pkg::KindPara;
      cnt_q   <= '0;
    end else begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      skip_q  <= skip_d;
      depth_q <= depth_d;
      err_q   <= err_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
    end
  end

  // A push writes the old top at its final place. The entry just below the
  // next top is prefetched every cycle, so a pop can take it without a stall.
  // After a push that entry is the old top, which is being written in the
  // same cycle, so it is taken straight from top_q instead of the memory.
  assign rd_depth = depth_d - DepthW'(2);

  always_ff @(posedge clk_i) begin
    if (accept && !last && push && depth_q != '0) begin
      stack_mem[AddrW'(depth_q - DepthW'(1))] <= top_q;
    end
    if (depth_d >= DepthW'(2)) begin
      if (accept && !last && push) begin
        below_q <= top_q;
      end else begin
        below_q <= stack_mem[rd_depth[AddrW-1:0]];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      bal_q     <= (final_err == tnc_pkg::ErrNone);
      res_err_q <= final_err;
      res_cnt_q <= (final_err == tnc_pkg::ErrNone) ? cnt_e : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.balanced     = bal_q;
  assign out_o.error_code   = res_err_q;
  assign out_o.para_pairs   = res_cnt_q[tnc_pkg::KindPara];
  assign out_o.bold_pairs   = res_cnt_q[tnc_pkg::KindBold];
  assign out_o.italic_pairs = res_cnt_q[tnc_pkg::KindItalic];
  assign out_o.quote_pairs  = res_cnt_q[tnc_pkg::KindQuote];

endmodule

@@ test/tb_top.sv @@
module tb_top;

  localparam int unsigned CountBits     = tnc_pkg::CountWidthDef;
  localparam int unsigned StackSize     = tnc_pkg::StackDepthDef;
  // Random stimulus length in words, and the receiver hold-off used to back
  // the block up.
  localparam int unsigned RandomChars   = 730;
  localparam int unsigned HoldCycles    = 300;
  // Longest normal stall is a sender gap on top of a receiver gap. The
  // hold-off above is far longer, so the limit covers it with a wide margin.
  localparam int unsigned WatchdogLimit = 2000;
  // Drain time after the last expected result, to catch stray results.
  localparam int unsigned DrainCycles   = 4;

  // One result word as the block reports it.
  typedef struct packed {
    logic                 balanced;
    tnc_pkg::err_t        code;
    logic [CountBits-1:0] para;
    logic [CountBits-1:0] bold;
    logic [CountBits-1:0] italic;
    logic [CountBits-1:0] quote;
  } nest_result_t;

  // How often a side pauses before its next word.
  typedef enum int {
    IdleNone,
    IdleSome,
    IdleFull
  } idle_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  tnc_in_if                             in_if ();
  tnc_out_if #(.CountWidth(CountBits))  out_if ();

  tag_nesting_checker_core #(
    .StackDepth(StackSize),
    .CountWidth(CountBits)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Nesting predictor. It mirrors the block's line state: the three-byte
  // window starting at the position being scanned, the skip count inside a
  // matched tag, the kind stack, the first error and the pair counts.
  // ---------------------------------------------------------------------------
  logic [23:0]          scan_window;
  int unsigned          window_bytes;
  int unsigned          skip_count;
  tnc_pkg::kind_code_t  kind_stack [StackSize];
  int unsigned          stack_level;
  tnc_pkg::err_t        first_error;
  logic [CountBits-1:0] pair_count [4];

  nest_result_t expected_results[$];

  function automatic void clear_line_state();
    scan_window  = '0;
    window_bytes = 0;
    skip_count   = 0;
    stack_level  = 0;
    first_error  = tnc_pkg::ErrNone;
    for (int i = 0; i < 4; i++) pair_count[i] = '0;
  endfunction

  // Returns 1 when the byte is one of the four tag letters, with its kind.
  function automatic bit tag_letter(input logic [7:0] c, output tnc_pkg::kind_code_t k);
    k = tnc_pkg::KindPara;
    case (c)
      tnc_pkg::ChP: k = tnc_pkg::KindPara;
      tnc_pkg::ChB: k = tnc_pkg::KindBold;
      tnc_pkg::ChI: k = tnc_pkg::KindItalic;
      tnc_pkg::ChQ: k = tnc_pkg::KindQuote;
      default:      return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Scans one byte position, b0 being the byte at that position.
  function automatic void scan_position(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
    tnc_pkg::kind_code_t k;
    // Once an error is latched, nothing else on the line is looked at.
    if (first_error != tnc_pkg::ErrNone) return;
    if (skip_count != 0) begin
      skip_count--;
      return;
    end
    if (b0 == tnc_pkg::ChLt && b2 == tnc_pkg::ChGt && tag_letter(b1, k)) begin
      if (stack_level >= StackSize) begin
        first_error = tnc_pkg::ErrOverflow;
      end else begin
        kind_stack[stack_level] = k;
        stack_level++;
      end
      skip_count = 2;
      return;
    end
    if (b0 == tnc_pkg::ChLt && b1 == tnc_pkg::ChSlash && b3 == tnc_pkg::ChGt &&
        tag_letter(b2, k)) begin
      if (stack_level > 0 && kind_stack[stack_level - 1] == k) begin
        stack_level--;
        if (pair_count[k] != {CountBits{1'b1}}) pair_count[k]++;
      end else begin
        first_error = tnc_pkg::ErrMismatch;
      end
      skip_count = 3;
    end
  endfunction

  // Takes one accepted word. Returns 1 with the line result when the word
  // closes the line.
  function automatic bit predict_word(input logic [7:0] c, input logic is_last,
                                      output nest_result_t res);
    logic [7:0]  w [4];
    int unsigned n;
    int unsigned i;
    res = '0;
    // The new byte completes the window for the oldest buffered position.
    if (window_bytes >= 3) begin
      scan_position(scan_window[7:0], scan_window[15:8], scan_window[23:16], c);
      scan_window = {c, scan_window[23:8]};
    end else begin
      scan_window[8*window_bytes +: 8] = c;
      window_bytes++;
    end
    if (!is_last) return 1'b0;

    // Positions still buffered are scanned with zero bytes behind them, so a
    // tag cut off by the end of the line never completes.
    n = window_bytes;
    for (i = 0; i < 3; i++) w[i] = (i < n) ? scan_window[8*i +: 8] : 8'h00;
    w[3] = 8'h00;
    for (i = 0; i < n; i++) begin
      scan_position(w[0], w[1], w[2], w[3]);
      w[0] = w[1];
      w[1] = w[2];
      w[2] = w[3];
      w[3] = 8'h00;
    end

    if (first_error == tnc_pkg::ErrNone && stack_level != 0) begin
      first_error = tnc_pkg::ErrUnclosed;
    end
    res.balanced = (first_error == tnc_pkg::ErrNone);
    res.code     = first_error;
    if (res.balanced) begin
      res.para   = pair_count[tnc_pkg::KindPara];
      res.bold   = pair_count[tnc_pkg::KindBold];
      res.italic = pair_count[tnc_pkg::KindItalic];
      res.quote  = pair_count[tnc_pkg::KindQuote];
    end
    clear_line_state();
    return 1'b1;
  endfunction

  // Every accepted input word goes through the predictor; a closing word
  // queues the result the block owes for that line.
  always @(posedge clk) begin : word_monitor
    nest_result_t line_result;
    if (rst_n && in_if.valid && in_if.ready) begin
      if (predict_word(in_if.char_in, in_if.last_char, line_result)) begin
        expected_results.push_back(line_result);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
             results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  always @(posedge clk) begin : result_check
    nest_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with no line pending", 32'd1, 32'd0);
      end else begin
        want = expected_results.pop_front();
        check_field("balanced", 32'(out_if.balanced), 32'(want.balanced));
        check_field("error_code", 32'(out_if.error_code), 32'(want.code));
        check_field("para_pairs", 32'(out_if.para_pairs), 32'(want.para));
        check_field("bold_pairs", 32'(out_if.bold_pairs), 32'(want.bold));
        check_field("italic_pairs", 32'(out_if.italic_pairs), 32'(want.italic));
        check_field("quote_pairs", 32'(out_if.quote_pairs), 32'(want.quote));
      end
      results_seen++;
    end
  end

  // The run ends if neither channel moves a word for too long.
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling on both sides.
  // ---------------------------------------------------------------------------
  idle_mode_e  src_idle      = IdleNone;
  idle_mode_e  snk_idle      = IdleNone;
  int unsigned sink_hold_req = 0;

  function automatic int unsigned idle_cycles(input idle_mode_e m);
    case (m)
      IdleNone: return 0;
      IdleSome: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      default:  return $urandom_range(0, 16);
    endcase
  endfunction

  // Receiver: may pause before each result word, and takes a long hold-off
  // whenever one is requested. A request also cuts short a wait for a result,
  // so the hold starts even when no line is in flight.
  initial begin : result_sink
    int unsigned hold;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_req != 0) begin
        hold          = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        hold = idle_cycles(snk_idle);
      end
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk);
      while (!(out_if.valid && out_if.ready) && sink_hold_req == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  int unsigned chars_sent = 0;
  logic [7:0]  line_buf[$];

  // Sends one word and returns once it is accepted. Valid stays high across
  // back-to-back words and drops only for a gap.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int unsigned gap;
    gap = idle_cycles(src_idle);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_in   <= c;
    in_if.last_char <= is_last;
    do @(posedge clk);
    while (!in_if.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit ends_line);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], ends_line && (i == s.len() - 1));
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_char(line_buf[i], i == line_buf.size() - 1);
    end
    line_buf.delete();
  endtask

  function automatic logic [7:0] kind_letter(input tnc_pkg::kind_code_t k);
    logic [7:0] c;
    c = tnc_pkg::ChQ;
    case (k)
      tnc_pkg::KindPara:   c = tnc_pkg::ChP;
      tnc_pkg::KindBold:   c = tnc_pkg::ChB;
      tnc_pkg::KindItalic: c = tnc_pkg::ChI;
      tnc_pkg::KindQuote:  c = tnc_pkg::ChQ;
    endcase
    return c;
  endfunction

  // Bytes that are mostly tag characters, for noise lines and corruption.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0, 7:    return tnc_pkg::ChLt;
      1:       return tnc_pkg::ChGt;
      2:       return tnc_pkg::ChSlash;
      3:       return tnc_pkg::ChP;
      4:       return tnc_pkg::ChB;
      5:       return tnc_pkg::ChI;
      6:       return tnc_pkg::ChQ;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_tag(input tnc_pkg::kind_code_t k, input bit closing);
    line_buf.push_back(tnc_pkg::ChLt);
    if (closing) line_buf.push_back(tnc_pkg::ChSlash);
    line_buf.push_back(kind_letter(k));
    line_buf.push_back(tnc_pkg::ChGt);
  endfunction

  // Text between tags: mostly lowercase letters, now and then any byte.
  function automatic void put_filler(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
      else line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end
  endfunction

  // Builds a properly nested line with random kinds, depth and filler.
  function automatic void build_nested(input int unsigned steps, input int unsigned max_depth);
    tnc_pkg::kind_code_t open_kinds[$];
    tnc_pkg::kind_code_t k;
    int unsigned act;
    repeat (steps) begin
      act = $urandom_range(0, 2);
      if (act == 0 && open_kinds.size() < max_depth) begin
        k = tnc_pkg::kind_code_t'($urandom_range(0, 3));
        open_kinds.push_back(k);
        put_tag(k, 1'b0);
      end else if (act == 1 && open_kinds.size() > 0) begin
        put_tag(open_kinds.pop_back(), 1'b1);
      end else begin
        put_filler($urandom_range(0, 3));
      end
    end
    while (open_kinds.size() > 0) put_tag(open_kinds.pop_back(), 1'b1);
    if (line_buf.size() == 0) line_buf.push_back(noise_byte());
  endfunction

  // Damages a line: cuts it short (possibly inside a tag), overwrites, drops
  // or inserts one byte.
  function automatic void break_line();
    int unsigned at;
    at = $urandom_range(0, line_buf.size() - 1);
    case ($urandom_range(0, 3))
      0:       while (line_buf.size() > at + 1) void'(line_buf.pop_back());
      1:       line_buf[at] = noise_byte();
      2:       if (line_buf.size() > 1) line_buf.delete(at);
      default: line_buf.insert(at, noise_byte());
    endcase
  endfunction

  // Extreme bytes, lines shorter than the window, a nested pair of two kinds,
  // a close on an empty stack followed by text the sticky error must hide,
  // and a closing tag cut off by the end of the line.
  task automatic test_directed();
    src_idle = IdleSome;
    snk_idle = IdleSome;
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("<b>", 1'b1);
    send_text("<p><q></q></p>", 1'b1);
    send_text("</i><b>", 1'b1);
    send_text("<b></b", 1'b1);
  endtask

  // Fills the stack exactly, then pushes past it, then hits a full stack
  // with a wrong close, then leaves a full stack open at the end.
  task automatic test_stack_limit();
    src_idle = IdleSome;
    snk_idle = IdleFull;
    repeat (StackSize) send_text("<i>", 1'b0);
    repeat (StackSize - 1) send_text("</i>", 1'b0);
    send_text("</i>", 1'b1);

    repeat (StackSize + 1) send_text("<q>", 1'b0);
    send_text("</q></q>", 1'b1);

    repeat (StackSize) send_text("<p>", 1'b0);
    send_text("</b><p>", 1'b1);

    repeat (StackSize) send_text("<b>", 1'b0);
    send_text("x", 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering lines, so the pending result stalls the input.
  task automatic test_backpressure();
    src_idle      = IdleNone;
    snk_idle      = IdleNone;
    sink_hold_req = HoldCycles;
    repeat (6) begin
      build_nested(6, 4);
      send_line();
    end
  endtask

  // Mostly well-formed lines with random content, the rest damaged lines and
  // tag-heavy noise. Idling changes from line to line.
  task automatic test_random_lines();
    int unsigned first;
    int unsigned shape;
    first = chars_sent;
    while (chars_sent - first < RandomChars) begin
      src_idle = idle_mode_e'($urandom_range(0, 2));
      snk_idle = idle_mode_e'($urandom_range(0, 2));
      shape    = $urandom_range(0, 19);
      if (shape == 0) begin
        build_nested(120, StackSize);
      end else if (shape < 14) begin
        build_nested($urandom_range(1, 24), $urandom_range(1, 8));
      end else if (shape < 17) begin
        build_nested($urandom_range(1, 24), $urandom_range(1, 8));
        break_line();
      end else begin
        repeat ($urandom_range(1, 40)) line_buf.push_back(noise_byte());
      end
      send_line();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_in   = 8'h00;
    in_if.last_char = 1'b0;
    clear_line_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_stack_limit();
    test_backpressure();
    test_random_lines();

    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
